@@ hdl/bvte_pkg.sv @@
// Shared types and codes for the bounded value table engine.
// Holds op and status codes, the cell control struct and the default capacity.
// No dependencies.
`default_nettype none
package bvte_pkg;

  localparam int BVTE_CAPACITY = 16;

  localparam logic [2:0] OP_APPEND    = 3'd0;
  localparam logic [2:0] OP_DEL_FIRST = 3'd1;
  localparam logic [2:0] OP_DEL_ALL   = 3'd2;
  localparam logic [2:0] OP_SORT_ASC  = 3'd3;
  localparam logic [2:0] OP_SORT_DESC = 3'd4;
  localparam logic [2:0] OP_QUERY     = 3'd5;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NOMATCH = 2'd2;

  typedef enum logic [1:0] {
    SWK_COMPACT,
    SWK_ASC,
    SWK_DESC
  } swap_kind_t;

  typedef struct packed {
    logic       mark_clr;
    logic       mark_step;
    logic       kill_set;
    logic       del_all;
    logic       swap_step;
    logic       parity;
    swap_kind_t swap_kind;
    logic       copy_load;
    logic       copy_rot;
    logic       cnt_step;
    logic       cnt_shift;
  } cell_ctl_t;

endpackage
`default_nettype wire

@@ hdl/bounded_value_table_engine_unit.sv @@
// Top level: control sequencer, row of CAPACITY list cells and the statistics unit.
// Depends on bvte_pkg, bvte_cell and bvte_stats.
//
//  channel | ports                                  | handshake
//  input   | in_op, in_value                        | start && !busy
//  result  | out_status .. out_most_frequent        | out_valid, one cycle
//
// Append and query run load, count and scan; sorts first run an odd-even sort
// pass, deletes a mark pass and an odd-even compaction pass. Count and scan are
// the two rotations of the copy ring. A delete with no match skips compaction.
// rst_n is synchronous; it clears the sequencer and the list size.
// The receiver cannot stall: out_valid is high for exactly one cycle per result.
`default_nettype none
module bounded_value_table_engine_unit
  import bvte_pkg::*;
#(
  parameter int CAPACITY = BVTE_CAPACITY
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         in_op,
  input  wire logic signed [31:0] in_value,
  output logic                    out_valid,
  output logic [1:0]              out_status,
  output logic [4:0]              out_position,
  output logic [4:0]              out_match_count,
  output logic [4:0]              out_occupancy,
  output logic                    out_is_empty,
  output logic                    out_is_full,
  output logic signed [35:0]      out_total,
  output logic signed [31:0]      out_smallest,
  output logic signed [31:0]      out_largest,
  output logic signed [31:0]      out_most_frequent
);

  localparam int N  = CAPACITY;
  localparam int IW = $clog2(N);
  localparam int CW = $clog2(N+1);

  typedef enum logic [2:0] {
    S_IDLE, S_MARK, S_COMPACT, S_SORT, S_LOAD, S_COUNT, S_SCAN
  } state_t;

  state_t             state_r;
  logic [IW-1:0]      t_r;
  logic [CW-1:0]      count_r;
  logic [2:0]         op_r;
  logic signed [31:0] x_r;
  logic [1:0]         status_r;
  logic               out_valid_r;

  logic               acc;
  logic               last;
  logic signed [31:0] x_bus;
  cell_ctl_t          ctl;

  logic signed [31:0] e_w   [N];
  logic               k_w   [N];
  logic               sw_w  [N];
  logic               sn_w  [N];
  logic [CW-1:0]      pm_w  [N];
  logic signed [31:0] c_w   [N];
  logic               cv_w  [N];
  logic [CW-1:0]      cnt_w [N];
  logic               v_w   [N];

  logic signed [35:0] sum_w;
  logic signed [31:0] mn_w;
  logic signed [31:0] mx_w;
  logic signed [31:0] mode_w;
  logic [CW-1:0]      pos_w;
  logic [CW-1:0]      mcnt_w;

  assign busy  = (state_r != S_IDLE);
  assign acc   = start && !busy;
  assign last  = (t_r == IW'(N - 1));
  assign x_bus = (state_r == S_IDLE) ? in_value : x_r;

  always_comb begin
    ctl           = '0;
    ctl.swap_kind = SWK_COMPACT;
    ctl.del_all   = (op_r == OP_DEL_ALL);
    ctl.parity    = t_r[0];
    case (state_r)
      S_IDLE:    ctl.mark_clr = acc && (in_op == OP_DEL_FIRST || in_op == OP_DEL_ALL);
      S_MARK: begin
        ctl.mark_step = 1'b1;
        ctl.kill_set  = last;
      end
      S_COMPACT: ctl.swap_step = 1'b1;
      S_SORT: begin
        ctl.swap_step = 1'b1;
        ctl.swap_kind = (op_r == OP_SORT_DESC) ? SWK_DESC : SWK_ASC;
      end
      S_LOAD:    ctl.copy_load = 1'b1;
      S_COUNT: begin
        ctl.copy_rot = 1'b1;
        ctl.cnt_step = 1'b1;
      end
      S_SCAN: begin
        ctl.copy_rot  = 1'b1;
        ctl.cnt_shift = 1'b1;
      end
      default: ctl.swap_kind = SWK_COMPACT;
    endcase
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    localparam int RT = (i + 1) % N;
    localparam int LT = (i + N - 1) % N;
    logic app_en;
    assign app_en = acc && (in_op == OP_APPEND) && (count_r == CW'(i));
    assign v_w[i] = (CW'(i) < count_r);

    bvte_cell #(.N(N), .IDX(i)) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .x        (x_bus),
      .app_en   (app_en),
      .valid    (v_w[i]),
      .e_l      (e_w[LT]),
      .k_l      (k_w[LT]),
      .swap_l   ((i == 0) ? 1'b0 : sw_w[LT]),
      .e_rt     (e_w[RT]),
      .k_rt     (k_w[RT]),
      .v_rt     ((i == N - 1) ? 1'b0 : v_w[RT]),
      .seen_in  ((i == 0) ? 1'b0 : sn_w[LT]),
      .pm_in    ((i == 0) ? CW'(0) : pm_w[LT]),
      .c_in     (c_w[RT]),
      .cv_in    (cv_w[RT]),
      .cnt_in   (cnt_w[RT]),
      .e_o      (e_w[i]),
      .k_o      (k_w[i]),
      .swap_o   (sw_w[i]),
      .seen_out (sn_w[i]),
      .pm_out   (pm_w[i]),
      .c_o      (c_w[i]),
      .cv_o     (cv_w[i]),
      .cnt_o    (cnt_w[i])
    );
  end

  bvte_stats #(.N(N)) u_stats (
    .clk    (clk),
    .ctl    (ctl),
    .t      (t_r),
    .x      (x_r),
    .c0     (c_w[0]),
    .cv0    (cv_w[0]),
    .cnt0   (cnt_w[0]),
    .sum_o  (sum_w),
    .mn_o   (mn_w),
    .mx_o   (mx_w),
    .mode_o (mode_w),
    .pos_o  (pos_w),
    .mcnt_o (mcnt_w)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      t_r         <= '0;
      count_r     <= '0;
      op_r        <= OP_QUERY;
      x_r         <= '0;
      status_r    <= ST_DONE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (acc) begin
            op_r     <= in_op;
            x_r      <= in_value;
            t_r      <= '0;
            status_r <= ST_DONE;
            case (in_op)
              OP_APPEND: begin
                if (count_r == CW'(N)) begin
                  status_r <= ST_FULL;
                end else begin
                  count_r <= count_r + CW'(1);
                end
                state_r <= S_LOAD;
              end
              OP_DEL_FIRST, OP_DEL_ALL:  state_r <= S_MARK;
              OP_SORT_ASC, OP_SORT_DESC: state_r <= S_SORT;
              default:                   state_r <= S_LOAD;
            endcase
          end
        end
        S_MARK: begin
          t_r <= t_r + IW'(1);
          if (last) begin
            t_r <= '0;
            // last cell's outputs now cover the whole row
            if (!sn_w[N-1]) begin
              status_r <= ST_NOMATCH;
              state_r  <= S_LOAD;
            end else begin
              count_r <= count_r - ((op_r == OP_DEL_ALL) ? pm_w[N-1] : CW'(1));
              state_r <= S_COMPACT;
            end
          end
        end
        S_COMPACT, S_SORT: begin
          t_r <= t_r + IW'(1);
          if (last) begin
            t_r     <= '0;
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          t_r     <= '0;
          state_r <= S_COUNT;
        end
        S_COUNT: begin
          t_r <= t_r + IW'(1);
          if (last) begin
            t_r     <= '0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          t_r <= t_r + IW'(1);
          if (last) begin
            t_r         <= '0;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_position      = 5'(pos_w);
  assign out_match_count   = 5'(mcnt_w);
  assign out_occupancy     = 5'(count_r);
  assign out_is_empty      = (count_r == '0);
  assign out_is_full       = (count_r == CW'(N));
  assign out_total         = sum_w;
  assign out_smallest      = mn_w;
  assign out_largest       = mx_w;
  assign out_most_frequent = mode_w;

  a_strobe_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == S_SCAN) && !busy)
    else $error("result strobe without a finished scan");

  a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(N))
    else $error("list size beyond capacity");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy && !out_valid)
    else $error("accepted item did not start work");

  a_status_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> out_is_full)
    else $error("full status on a list that is not full");

endmodule
`default_nettype wire

@@ hdl/bvte_cell.sv @@
// One slot of the list: entry, kill flag, match prefix chain and circulating copy.
// Depends on bvte_pkg.
`default_nettype none
module bvte_cell
  import bvte_pkg::*;
#(
  parameter int N   = BVTE_CAPACITY,
  parameter int IDX = 0
) (
  input  wire logic                          clk,
  input  wire cell_ctl_t                     ctl,
  input  wire logic signed [31:0]            x,
  input  wire logic                          app_en,
  input  wire logic                          valid,
  input  wire logic signed [31:0]            e_l,
  input  wire logic                          k_l,
  input  wire logic                          swap_l,
  input  wire logic signed [31:0]            e_rt,
  input  wire logic                          k_rt,
  input  wire logic                          v_rt,
  input  wire logic                          seen_in,
  input  wire logic [$clog2(N+1)-1:0]        pm_in,
  input  wire logic signed [31:0]            c_in,
  input  wire logic                          cv_in,
  input  wire logic [$clog2(N+1)-1:0]        cnt_in,
  output logic signed [31:0]                 e_o,
  output logic                               k_o,
  output logic                               swap_o,
  output logic                               seen_out,
  output logic [$clog2(N+1)-1:0]             pm_out,
  output logic signed [31:0]                 c_o,
  output logic                               cv_o,
  output logic [$clog2(N+1)-1:0]             cnt_o
);

  localparam int   CW     = $clog2(N+1);
  localparam logic ODD    = 1'(IDX % 2);
  localparam logic HAS_RT = (IDX < N - 1);

  logic signed [31:0] e_r;
  logic               k_r;
  logic               seen_r;
  logic [CW-1:0]      pm_r;
  logic signed [31:0] c_r;
  logic               cv_r;
  logic [CW-1:0]      cnt_r;
  logic               m;
  logic               cond;

  assign m = valid && (e_r == x);

  always_comb begin
    case (ctl.swap_kind)
      SWK_COMPACT: cond = k_r && !k_rt;
      SWK_ASC:     cond = valid && v_rt && (e_r > e_rt);
      SWK_DESC:    cond = valid && v_rt && (e_r < e_rt);
      default:     cond = 1'b0;
    endcase
  end

  assign swap_o   = ctl.swap_step && HAS_RT && (ODD == ctl.parity) && cond;
  assign seen_out = seen_r || m;
  assign pm_out   = pm_r + CW'(m);

  always_ff @(posedge clk) begin
    if (app_en) begin
      e_r <= x;
    end else if (swap_o) begin
      e_r <= e_rt;
      k_r <= k_rt;
    end else if (swap_l) begin
      e_r <= e_l;
      k_r <= k_l;
    end else if (ctl.kill_set) begin
      k_r <= !valid || (ctl.del_all ? m : (m && !seen_r));
    end
    if (ctl.mark_clr) begin
      seen_r <= 1'b0;
      pm_r   <= '0;
    end else if (ctl.mark_step) begin
      seen_r <= seen_in;
      pm_r   <= pm_in;
    end
    if (ctl.copy_load) begin
      c_r   <= e_r;
      cv_r  <= valid;
      cnt_r <= '0;
    end else if (ctl.copy_rot) begin
      c_r  <= c_in;
      cv_r <= cv_in;
      if (ctl.cnt_shift) begin
        cnt_r <= cnt_in;
      end else if (ctl.cnt_step && cv_r && (c_r == e_r)) begin
        cnt_r <= cnt_r + CW'(1);
      end
    end
  end

  assign e_o   = e_r;
  assign k_o   = k_r;
  assign c_o   = c_r;
  assign cv_o  = cv_r;
  assign cnt_o = cnt_r;

endmodule
`default_nettype wire

@@ hdl/bvte_stats.sv @@
// Accumulates list statistics from the entries streaming past slot 0.
// Depends on bvte_pkg.
`default_nettype none
module bvte_stats
  import bvte_pkg::*;
#(
  parameter int N = BVTE_CAPACITY
) (
  input  wire logic                       clk,
  input  wire cell_ctl_t                  ctl,
  input  wire logic [$clog2(N)-1:0]       t,
  input  wire logic signed [31:0]         x,
  input  wire logic signed [31:0]         c0,
  input  wire logic                       cv0,
  input  wire logic [$clog2(N+1)-1:0]     cnt0,
  output logic signed [35:0]              sum_o,
  output logic signed [31:0]              mn_o,
  output logic signed [31:0]              mx_o,
  output logic signed [31:0]              mode_o,
  output logic [$clog2(N+1)-1:0]          pos_o,
  output logic [$clog2(N+1)-1:0]          mcnt_o
);

  localparam int CW = $clog2(N+1);

  logic signed [35:0] sum_r;
  logic signed [31:0] mn_r;
  logic signed [31:0] mx_r;
  logic signed [31:0] mode_r;
  logic [CW-1:0]      pos_r;
  logic [CW-1:0]      mcnt_r;
  logic [CW-1:0]      best_r;

  always_ff @(posedge clk) begin
    if (ctl.copy_load) begin
      sum_r  <= '0;
      mn_r   <= '0;
      mx_r   <= '0;
      mode_r <= '0;
      pos_r  <= '0;
      mcnt_r <= '0;
      best_r <= '0;
    end else if (ctl.cnt_step && cv0) begin
      sum_r <= sum_r + 36'(c0);
      // valid entries form a prefix, so the first one arrives at step zero
      if (t == '0 || c0 < mn_r) mn_r <= c0;
      if (t == '0 || c0 > mx_r) mx_r <= c0;
      if (c0 == x) begin
        mcnt_r <= mcnt_r + CW'(1);
        if (pos_r == '0) pos_r <= CW'(t) + CW'(1);
      end
    end else if (ctl.cnt_shift && cv0 && (cnt0 > best_r)) begin
      best_r <= cnt0;
      mode_r <= c0;
    end
  end

  assign sum_o  = sum_r;
  assign mn_o   = mn_r;
  assign mx_o   = mx_r;
  assign mode_o = mode_r;
  assign pos_o  = pos_r;
  assign mcnt_o = mcnt_r;

endmodule
`default_nettype wire
